/* rtl/fsrp_pkg.sv */
package fsrp_pkg;

  // Line length limit; counters stop at the smaller of this and 16 bits.
  localparam logic [31:0] MAX_LINE_LEN = 32'd65535;
  localparam logic [15:0] LEN_CAP =
    (MAX_LINE_LEN > 32'd65535) ? 16'hFFFF : MAX_LINE_LEN[15:0];

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_AT = 8'h40;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  localparam logic [1:0] FLD_HDR  = 2'd0;
  localparam logic [1:0] FLD_SEQ  = 2'd1;
  localparam logic [1:0] FLD_QUAL = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Line position inside a record.
  localparam logic [1:0] SLOT_HDR  = 2'd0;
  localparam logic [1:0] SLOT_SEQ  = 2'd1;
  localparam logic [1:0] SLOT_PLUS = 2'd2;
  localparam logic [1:0] SLOT_QUAL = 2'd3;

  // Size of the result list; one input request causes at most two results.
  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  field;
    logic [1:0]  kind;
    logic [15:0] seq_keep_len;
    logic [15:0] qual_keep_len;
    logic        last;
  } out_t;

endpackage

/* rtl/fastq_stream_record_parser.sv */
// FASTQ record parser.
//
// Input channel (item_valid / item_stall / item): one request per cycle
// unless stalled; a text byte (opcode 0) or end-of-stream mark (opcode 1).
// Output channel (result_valid / result_stall / result): tagged header,
// sequence and quality bytes, record-end requests with keep lengths, and
// a dropped mark for a record cut short by end of stream. result.last
// flags the final result caused by one input request.
//
// An accepted request waits in the input register, its results in the
// result register. Throughput: one request per cycle if it causes at
// most one result and nothing stalls; a request with k results holds
// the input register until its last result loads, as the single output
// register takes one result a cycle. Requests with no result (plus line
// bytes, a held return) retire without touching the output side.
//
// Reset (rst, synchronous) empties both registers and returns the parser
// to the start of a header line. When the receiver stalls, the result
// register holds; the input register keeps its request and item_stall
// rises once the pending request cannot retire.
module fastq_stream_record_parser
  import fsrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  in_t  item,
  output logic result_valid,
  input  logic result_stall,
  output out_t result
);

  // Input register and position within its result list
  logic       cur_valid;
  in_t        cur;
  logic [1:0] cur_idx;

  // Parser state
  logic [1:0]  line_slot;
  logic        held_return;
  logic        line_bytes_seen;
  logic        header_was_fixed;
  logic [15:0] seq_length;
  logic [15:0] qual_length;

  // Next state once the pending request retires
  logic [1:0]  line_slot_next;
  logic        held_return_next;
  logic        line_bytes_seen_next;
  logic        header_was_fixed_next;
  logic [15:0] seq_length_next;
  logic [15:0] qual_length_next;

  out_t       res [MAX_RESULTS];
  logic [1:0] res_count;

  logic out_free;
  logic load_out;
  logic done;

  function automatic out_t mk(logic [7:0] b, logic [1:0] fld, logic [1:0] knd,
                              logic [15:0] sk, logic [15:0] qk);
    out_t r;
    r.out_byte      = b;
    r.field         = fld;
    r.kind          = knd;
    r.seq_keep_len  = sk;
    r.qual_keep_len = qk;
    r.last          = 1'b0;
    return r;
  endfunction

  // Result list and state update for the pending request.
  always_comb begin
    logic [1:0]  s_slot;
    logic        s_held;
    logic        s_seen;
    logic        s_fixed;
    logic [15:0] s_seq;
    logic [15:0] s_qual;
    logic [15:0] keep_min;
    logic        do_end;
    logic        do_clear;
    logic        step_en   [2];
    logic [7:0]  step_byte [2];
    logic        step_emit [2];

    s_slot   = line_slot;
    s_held   = held_return;
    s_seen   = line_bytes_seen;
    s_fixed  = header_was_fixed;
    s_seq    = seq_length;
    s_qual   = qual_length;
    do_end   = 1'b0;
    do_clear = 1'b0;
    res_count = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = mk(8'd0, FLD_HDR, KIND_DATA, 16'd0, 16'd0);
    end
    for (int k = 0; k < 2; k++) begin
      step_en[k]   = 1'b0;
      step_byte[k] = CH_CR;
      step_emit[k] = 1'b0;
    end
    keep_min = (seq_length < qual_length) ? seq_length : qual_length;

    if (cur.opcode == OP_EOS) begin
      do_clear = 1'b1;
      if (line_slot == SLOT_QUAL && line_bytes_seen) begin
        do_end = 1'b1;
      end else if (line_slot != SLOT_HDR || line_bytes_seen || header_was_fixed) begin
        res[0]    = mk(8'd0, FLD_HDR, KIND_DROP, 16'd0, 16'd0);
        res_count = 2'd1;
      end
    end else if (cur.data_byte == CH_NL) begin
      s_held = 1'b0;
      if (line_slot == SLOT_HDR && !line_bytes_seen && !header_was_fixed) begin
        res[0]    = mk(CH_AT, FLD_HDR, KIND_DATA, 16'd0, 16'd0);
        res_count = 2'd1;
        s_fixed   = 1'b1;
      end
      if (line_slot == SLOT_QUAL) begin
        do_end   = 1'b1;
        do_clear = 1'b1;
      end else begin
        s_slot = line_slot + 2'd1;
        s_seen = 1'b0;
      end
    end else begin
      // A held return becomes a line byte first; a new return only
      // checks the header fix, other bytes are line bytes.
      step_en[0]   = held_return;
      step_byte[0] = CH_CR;
      step_emit[0] = 1'b1;
      step_en[1]   = 1'b1;
      step_byte[1] = cur.data_byte;
      step_emit[1] = (cur.data_byte != CH_CR);
      s_held       = (cur.data_byte == CH_CR);

      for (int k = 0; k < 2; k++) begin
        if (step_en[k]) begin
          if (s_slot == SLOT_HDR && !s_seen && !s_fixed && step_byte[k] != CH_AT) begin
            if (res_count != 2'd3) begin
              res[res_count] = mk(CH_AT, FLD_HDR, KIND_DATA, 16'd0, 16'd0);
              res_count      = res_count + 2'd1;
            end
            s_fixed = 1'b1;
          end
          if (step_emit[k]) begin
            unique case (s_slot)
              SLOT_HDR: begin
                if (res_count != 2'd3) begin
                  res[res_count] = mk(step_byte[k], FLD_HDR, KIND_DATA, 16'd0, 16'd0);
                  res_count      = res_count + 2'd1;
                end
              end
              SLOT_SEQ: begin
                if (res_count != 2'd3) begin
                  res[res_count] = mk(step_byte[k], FLD_SEQ, KIND_DATA, 16'd0, 16'd0);
                  res_count      = res_count + 2'd1;
                end
                if (s_seq < LEN_CAP) s_seq = s_seq + 16'd1;
              end
              SLOT_PLUS: begin
              end
              SLOT_QUAL: begin
                if (res_count != 2'd3) begin
                  res[res_count] = mk(step_byte[k], FLD_QUAL, KIND_DATA, 16'd0, 16'd0);
                  res_count      = res_count + 2'd1;
                end
                if (s_qual < LEN_CAP) s_qual = s_qual + 16'd1;
              end
              default: begin
              end
            endcase
            s_seen = 1'b1;
          end
        end
      end
    end

    // Record end: lengths are trimmed to match only for a clean header.
    if (do_end && res_count != 2'd3) begin
      if (header_was_fixed || s_fixed) begin
        res[res_count] = mk(8'd0, FLD_HDR, KIND_END, seq_length, qual_length);
      end else begin
        res[res_count] = mk(8'd0, FLD_HDR, KIND_END, keep_min, keep_min);
      end
      res_count = res_count + 2'd1;
    end

    if (res_count != 2'd0) begin
      res[res_count - 2'd1].last = 1'b1;
    end

    if (do_clear) begin
      line_slot_next        = SLOT_HDR;
      held_return_next      = 1'b0;
      line_bytes_seen_next  = 1'b0;
      header_was_fixed_next = 1'b0;
      seq_length_next       = 16'd0;
      qual_length_next      = 16'd0;
    end else begin
      line_slot_next        = s_slot;
      held_return_next      = s_held;
      line_bytes_seen_next  = s_seen;
      header_was_fixed_next = s_fixed;
      seq_length_next       = s_seq;
      qual_length_next      = s_qual;
    end
  end

  // Handshake: a result moves into the output register whenever it is
  // empty or being drained; the request retires with its last result.
  assign out_free   = !result_valid || !result_stall;
  assign load_out   = cur_valid && (res_count != 2'd0) && out_free;
  assign done       = cur_valid &&
                      ((res_count == 2'd0) || (load_out && cur_idx == res_count - 2'd1));
  assign item_stall = cur_valid && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid        <= 1'b0;
      cur_idx          <= 2'd0;
      result_valid     <= 1'b0;
      line_slot        <= SLOT_HDR;
      held_return      <= 1'b0;
      line_bytes_seen  <= 1'b0;
      header_was_fixed <= 1'b0;
      seq_length       <= 16'd0;
      qual_length      <= 16'd0;
    end else begin
      if (item_valid && !item_stall) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end

      if (done) begin
        cur_idx          <= 2'd0;
        line_slot        <= line_slot_next;
        held_return      <= held_return_next;
        line_bytes_seen  <= line_bytes_seen_next;
        header_was_fixed <= header_was_fixed_next;
        seq_length       <= seq_length_next;
        qual_length      <= qual_length_next;
      end else if (load_out) begin
        cur_idx <= cur_idx + 2'd1;
      end

      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      cur <= item;
    end
    if (load_out) begin
      result <= res[cur_idx];
    end
  end

  // The result pointer stays inside the pending request's list.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid && res_count != 2'd0 |-> cur_idx < res_count)
    else $error("result index past end of list");

  // The last-marked result always retires its request.
  a_last_retires: assert property (@(posedge clk) disable iff (rst)
    load_out && res[cur_idx].last |-> done)
    else $error("last result loaded without retiring request");

  // A return held on the header line implies the header was fixed or begun.
  a_held_header: assert property (@(posedge clk) disable iff (rst)
    held_return && line_slot == SLOT_HDR |-> line_bytes_seen || header_was_fixed)
    else $error("held return on header line without fix");

  // An empty input register starts at the first result.
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> cur_idx == 2'd0)
    else $error("stale result index");

endmodule

/* tb/tb_fastq_stream_record_parser.sv */
module tb_fastq_stream_record_parser;
  import fsrp_pkg::*;

  // Random part stops once this many requests went out.
  localparam int RANDOM_ITEMS = 245;
  // Receiver hold-off: starts at this receiver cycle and lasts this long.
  localparam int HOLD_START = 40;
  localparam int HOLD_LEN = 60;
  // Quiet cycles after the last expected result has come back.
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_t item;
  logic result_valid;
  logic result_stall;
  out_t result;

  fastq_stream_record_parser i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run (every request causing two
  // results while the receiver stalls most cycles).
  initial begin
    #2_000_000;
    $display("[fastq_stream_record_parser] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Parser model: line position, held carriage return and record lengths.
  // ---------------------------------------------------------------------
  logic [1:0] prs_slot;
  logic prs_held_cr;
  logic prs_line_started;   // current line has a byte besides a held CR
  logic prs_hdr_fixed;      // '@' was inserted for this record
  logic [15:0] prs_seq_len;
  logic [15:0] prs_qual_len;

  out_t step_results[$];     // results of one request, built by the model
  out_t awaited_results[$];  // results the block still owes, oldest first

  int unsigned error_count;
  int unsigned burst_left;
  int unsigned rand_items;

  localparam out_t NO_CHECK = '0;

  function automatic out_t mk_result(logic [7:0] b, logic [1:0] fld, logic [1:0] knd,
                                     logic [15:0] sk, logic [15:0] qk, logic lst);
    out_t r;
    r.out_byte = b;
    r.field = fld;
    r.kind = knd;
    r.seq_keep_len = sk;
    r.qual_keep_len = qk;
    r.last = lst;
    return r;
  endfunction

  function automatic out_t byte_res(logic [7:0] b, logic [1:0] fld);
    return mk_result(b, fld, KIND_DATA, 16'd0, 16'd0, 1'b1);
  endfunction

  function automatic out_t end_res(logic [15:0] sk, logic [15:0] qk);
    return mk_result(8'h00, FLD_HDR, KIND_END, sk, qk, 1'b1);
  endfunction

  function automatic out_t drop_res();
    return mk_result(8'h00, FLD_HDR, KIND_DROP, 16'd0, 16'd0, 1'b1);
  endfunction

  function automatic void put_result(logic [7:0] b, logic [1:0] fld, logic [1:0] knd,
                                     logic [15:0] sk, logic [15:0] qk);
    step_results = {step_results, mk_result(b, fld, knd, sk, qk, 1'b0)};
  endfunction

  function automatic void reset_model();
    prs_slot = SLOT_HDR;
    prs_held_cr = 1'b0;
    prs_line_started = 1'b0;
    prs_hdr_fixed = 1'b0;
    prs_seq_len = '0;
    prs_qual_len = '0;
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] c);
    return (c < LEN_CAP) ? c + 16'd1 : c;
  endfunction

  // First header byte other than '@' gets an '@' in front of it.
  function automatic void maybe_insert_at(logic [7:0] b);
    if (prs_slot == SLOT_HDR && !prs_line_started && !prs_hdr_fixed && b != CH_AT) begin
      put_result(CH_AT, FLD_HDR, KIND_DATA, 16'd0, 16'd0);
      prs_hdr_fixed = 1'b1;
    end
  endfunction

  function automatic void take_line_byte(logic [7:0] b);
    case (prs_slot)
      SLOT_HDR: begin
        maybe_insert_at(b);
        put_result(b, FLD_HDR, KIND_DATA, 16'd0, 16'd0);
      end
      SLOT_SEQ: begin
        put_result(b, FLD_SEQ, KIND_DATA, 16'd0, 16'd0);
        prs_seq_len = sat_inc(prs_seq_len);
      end
      SLOT_PLUS: ;
      default: begin
        put_result(b, FLD_QUAL, KIND_DATA, 16'd0, 16'd0);
        prs_qual_len = sat_inc(prs_qual_len);
      end
    endcase
    prs_line_started = 1'b1;
  endfunction

  // A good header trims both lines to the shorter one; a repaired header
  // reports the raw lengths.
  function automatic void close_record();
    logic [15:0] sk;
    logic [15:0] qk;
    sk = prs_seq_len;
    qk = prs_qual_len;
    if (!prs_hdr_fixed) begin
      sk = (prs_seq_len < prs_qual_len) ? prs_seq_len : prs_qual_len;
      qk = sk;
    end
    put_result(8'h00, FLD_HDR, KIND_END, sk, qk);
    reset_model();
  endfunction

  function automatic void parse_request(in_t req);
    step_results.delete();
    if (req.opcode == OP_EOS) begin
      // held CR is simply lost; a started quality line still closes
      if (prs_slot == SLOT_QUAL && prs_line_started)
        close_record();
      else if (prs_slot != SLOT_HDR || prs_line_started || prs_hdr_fixed)
        put_result(8'h00, FLD_HDR, KIND_DROP, 16'd0, 16'd0);
      reset_model();
    end else if (req.data_byte == CH_NL) begin
      prs_held_cr = 1'b0;
      if (prs_slot == SLOT_HDR && !prs_line_started && !prs_hdr_fixed) begin
        put_result(CH_AT, FLD_HDR, KIND_DATA, 16'd0, 16'd0);
        prs_hdr_fixed = 1'b1;
      end
      if (prs_slot == SLOT_QUAL)
        close_record();
      else begin
        prs_slot = prs_slot + 2'd1;
        prs_line_started = 1'b0;
      end
    end else if (req.data_byte == CH_CR) begin
      // a second CR releases the first one as a plain line byte
      if (prs_held_cr)
        take_line_byte(CH_CR);
      maybe_insert_at(CH_CR);
      prs_held_cr = 1'b1;
    end else begin
      if (prs_held_cr) begin
        prs_held_cr = 1'b0;
        take_line_byte(CH_CR);
      end
      take_line_byte(req.data_byte);
    end
    if (step_results.size() > 0)
      step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Request helpers and the sender.
  // ---------------------------------------------------------------------
  function automatic in_t data_req(logic [7:0] b);
    in_t r;
    r.opcode = OP_DATA;
    r.data_byte = b;
    return r;
  endfunction

  function automatic in_t eos_req();
    in_t r;
    r.opcode = OP_EOS;
    r.data_byte = 8'($urandom_range(0, 255));  // ignored, but toggled anyway
    return r;
  endfunction

  // Offers one request at the falling edge and returns once it was taken.
  // Sender runs in bursts; a gap between bursts drops valid first.
  // A typed row replaces the model's results with the one typed in.
  task automatic offer(input in_t req, input bit typed, input out_t want);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= req;
    parse_request(req);
    if (typed)
      awaited_results = {awaited_results, want};
    else
      awaited_results = {awaited_results, step_results};
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // One record with random content, mostly well formed: LF or CRLF line
  // ends, header usually with '@'. Some get cut short by end of stream,
  // some end their quality line at end of stream, some close the stream.
  task automatic send_record();
    in_t reqs[$];
    int unsigned n;
    int unsigned pick;
    logic [7:0] b;
    for (int ln = 0; ln < 4; ln++) begin
      n = $urandom_range(0, 8);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          b = CH_CR;
        else if (pick == 1)
          b = 8'($urandom_range(0, 255));
        else
          b = 8'($urandom_range(33, 126));
        if (ln == 0 && k == 0 && $urandom_range(0, 4) != 0)
          b = CH_AT;
        reqs = {reqs, data_req(b)};
      end
      if ($urandom_range(0, 3) == 0)
        reqs = {reqs, data_req(CH_CR)};
      reqs = {reqs, data_req(CH_NL)};
    end
    case ($urandom_range(0, 7))
      0: begin
        n = $urandom_range(0, reqs.size() - 1);
        while (reqs.size() > n) reqs.delete(reqs.size() - 1);
        reqs = {reqs, eos_req()};
      end
      1: begin
        reqs.delete(reqs.size() - 1);
        reqs = {reqs, eos_req()};
      end
      2: reqs = {reqs, eos_req()};
      default: ;
    endcase
    foreach (reqs[i]) offer(reqs[i], 1'b0, NO_CHECK);
    rand_items += reqs.size();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall rate is redrawn among 0, 20, 50 and 85 percent, plus one
  // long hold-off so the block backs up into its input.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int unsigned rcv_cycle;
    int unsigned stall_pct;
    rcv_cycle = 0;
    stall_pct = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      rcv_cycle++;
      if (rcv_cycle % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_START + HOLD_LEN)
        result_stall <= 1'b1;
      else
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Result check at the rising edge, field by field against the oldest
  // awaited result.
  // ---------------------------------------------------------------------
  function automatic string show(out_t r);
    return $sformatf("byte=%02h field=%0d kind=%0d seq=%0d qual=%0d last=%0b",
                     r.out_byte, r.field, r.kind, r.seq_keep_len, r.qual_keep_len, r.last);
  endfunction

  function automatic void flag_error(string msg);
    if (error_count < 10)
      $display("%0t: %s", $realtime, msg);
    error_count++;
  endfunction

  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0)
        flag_error({"unexpected result: ", show(result)});
      else begin
        want = awaited_results.pop_front();
        if (result.out_byte !== want.out_byte || result.field !== want.field ||
            result.kind !== want.kind || result.seq_keep_len !== want.seq_keep_len ||
            result.qual_keep_len !== want.qual_keep_len || result.last !== want.last)
          flag_error({"mismatch: expected ", show(want), " got ", show(result)});
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed table: corners of each line kind and of end of stream.
  // Typed rows hold a result that is obvious from the text alone.
  // ---------------------------------------------------------------------
  typedef struct packed {
    in_t  req;
    logic typed;
    out_t want;
  } dir_row_t;

  dir_row_t directed [25];

  initial begin : stimulus
    int unsigned n;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    error_count = 0;
    burst_left = 0;
    rand_items = 0;
    reset_model();

    directed = '{
      // end of stream with nothing begun: silent
      '{eos_req(),            1'b0, NO_CHECK},
      // header starting with 0xFF: '@' inserted, then all-zero byte
      '{data_req(8'hFF),      1'b0, NO_CHECK},
      '{data_req(8'h00),      1'b1, byte_res(8'h00, FLD_HDR)},
      '{data_req(CH_NL),      1'b0, NO_CHECK},
      // sequence with a CR inside and a CRLF end
      '{data_req(8'h41),      1'b1, byte_res(8'h41, FLD_SEQ)},
      '{data_req(CH_CR),      1'b0, NO_CHECK},
      '{data_req(8'h43),      1'b0, NO_CHECK},
      '{data_req(CH_CR),      1'b0, NO_CHECK},
      '{data_req(CH_NL),      1'b0, NO_CHECK},
      // plus line: held CR released into a discarded line
      '{data_req(CH_CR),      1'b0, NO_CHECK},
      '{data_req(8'h2B),      1'b0, NO_CHECK},
      '{data_req(CH_NL),      1'b0, NO_CHECK},
      '{data_req(8'h49),      1'b1, byte_res(8'h49, FLD_QUAL)},
      // repaired header: raw lengths 3 and 1
      '{data_req(CH_NL),      1'b1, end_res(16'd3, 16'd1)},
      // good header, empty sequence, quality closed by end of stream
      '{data_req(CH_AT),      1'b1, byte_res(CH_AT, FLD_HDR)},
      '{data_req(CH_NL),      1'b0, NO_CHECK},
      '{data_req(CH_NL),      1'b0, NO_CHECK},
      '{data_req(CH_NL),      1'b0, NO_CHECK},
      '{data_req(8'h71),      1'b1, byte_res(8'h71, FLD_QUAL)},
      '{eos_req(),            1'b1, end_res(16'd0, 16'd0)},
      // empty header line, then cut off
      '{data_req(CH_NL),      1'b1, byte_res(CH_AT, FLD_HDR)},
      '{eos_req(),            1'b1, drop_res()},
      // CR as first header byte, double CR, cut off with a CR held
      '{data_req(CH_CR),      1'b1, byte_res(CH_AT, FLD_HDR)},
      '{data_req(CH_CR),      1'b0, NO_CHECK},
      '{eos_req(),            1'b1, drop_res()}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer(directed[i].req, directed[i].typed, directed[i].want);

    // Random part: mostly records, some raw noise requests.
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0)
            offer(eos_req(), 1'b0, NO_CHECK);
          else
            offer(data_req(8'($urandom_range(0, 255))), 1'b0, NO_CHECK);
        end
        rand_items += n;
      end else
        send_record();
    end

    item_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("[fastq_stream_record_parser] OK");
    else
      $display("[fastq_stream_record_parser] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/fsrp_pkg.sv
rtl/fastq_stream_record_parser.sv
tb/tb_fastq_stream_record_parser.sv
